### sv/kmp_pkg.sv
// kmp_pkg: shared types, codes and widths for the streaming KMP matcher.
// No dependencies; every other file of the matcher but kmp_checker imports it.
`default_nettype none

package kmp_pkg;

    localparam int REQ_W           = 2;
    localparam int CHAR_W          = 8;
    localparam int POS_W           = 32;
    localparam int CNT_W           = 16;
    localparam int ST_W            = 3;
    localparam int DEF_MAX_PATTERN = 64;
    localparam int Q_DEPTH         = 2;

    typedef enum logic [REQ_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_TEXT    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_NOPAT  = 3'd2,
        ST_LIMIT  = 3'd3,
        ST_POSSAT = 3'd4
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
    } t_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
        logic [CNT_W-1:0] total;
        t_status          status;
    } t_result;

endpackage

`default_nettype wire

### sv/kmp_stream_matcher.sv
// kmp_stream_matcher: top level of the streaming KMP matcher.
// Depends on kmp_pkg, kmp_front, kmp_engine and kmp_result_q.
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ----------------------------------------
//  request   in         push / full               i_req_type, i_char_value
//  result    out        empty / pop               o_match_found, o_match_start,
//                                                 o_match_total, o_status
//  config    in         i_cfg_we (no wait)        i_cfg_wdata (max_matches)
//
// Timing: every word first passes the request queue; clear, restart, a full or first append
// and a text word with no pattern finish in the engine's idle state, any other word also passes
// the compare state, one border fallback per cycle; fallbacks average at most one per text word.
// Reset (synchronous, active low) empties both queues and the pattern and text state, sets
// max_matches to 65535 and leaves the memories as they are.
// Stalls: two-entry queues at each end let producer, engine and consumer stall on their own.
`default_nettype none

module kmp_stream_matcher #(
    parameter int MAX_PATTERN = kmp_pkg::DEF_MAX_PATTERN
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [kmp_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [kmp_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [kmp_pkg::CHAR_W-1:0] i_char_value,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_match_found,
    output logic [kmp_pkg::POS_W-1:0]       o_match_start,
    output logic [kmp_pkg::CNT_W-1:0]       o_match_total,
    output logic [kmp_pkg::ST_W-1:0]        o_status
);
    import kmp_pkg::*;

    // request words between front and engine
    logic    item_valid;
    t_item   item;
    logic    item_pop;

    // result words between engine and output queue
    logic    res_push;
    logic    res_full;
    t_result res_in;
    t_result res_out;

    kmp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_req_type   (i_req_type),
        .i_char_value (i_char_value),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    // engine starts a word only while the output queue has room, so its
    // single result push never meets a full queue
    kmp_engine #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    kmp_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .o_res   (res_out),
        .i_pop   (pop)
    );

    // unpack the head result word onto its ports
    assign o_match_found = res_out.found;
    assign o_match_start = res_out.start;
    assign o_match_total = res_out.total;
    assign o_status      = res_out.status;

endmodule

`default_nettype wire

### sv/kmp_front.sv
// kmp_front: input queue; classifies each incoming word into an operation.
// Depends on kmp_pkg (t_item, t_op, Q_DEPTH).
`default_nettype none

module kmp_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    output logic                           o_full,
    input  wire logic [kmp_pkg::REQ_W-1:0] i_req_type,
    input  wire logic [kmp_pkg::CHAR_W-1:0] i_char_value,
    output logic                           o_item_valid,
    output kmp_pkg::t_item                 o_item,
    input  wire logic                      i_item_pop
);
    import kmp_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_item           r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    t_item           in_item;
    logic            wr;
    logic            rd;

    assign in_item.op   = t_op'(i_req_type);
    assign in_item.ch   = i_char_value;
    assign o_full       = (r_count == CW'(Q_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign wr           = i_push && !o_full;
    assign rd           = i_item_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + CW'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### sv/kmp_engine.sv
// kmp_engine: back end; holds pattern and border memories, runs the KMP steps.
// Depends on kmp_pkg (t_item, t_result, codes and widths).
`default_nettype none

module kmp_engine #(
    parameter int MAX_PATTERN = kmp_pkg::DEF_MAX_PATTERN
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [kmp_pkg::CNT_W-1:0] i_cfg_wdata,
    input  wire logic                      i_item_valid,
    input  wire kmp_pkg::t_item            i_item,
    output logic                           o_item_pop,
    input  wire logic                      i_res_full,
    output logic                           o_res_push,
    output kmp_pkg::t_result               o_res
);
    import kmp_pkg::*;

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);

    typedef enum logic {
        S_IDLE,
        S_CMP
    } t_state;

    logic [CHAR_W-1:0] mem_pat [MAX_PATTERN];
    logic [IW-1:0]     mem_bor [MAX_PATTERN];

    t_state            r_state, n_state;
    logic [LW-1:0]     r_len, n_len;
    logic [IW-1:0]     r_build, n_build;
    logic [IW-1:0]     r_cursor, n_cursor;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_max;
    t_op               r_op, n_op;
    logic [CHAR_W-1:0] r_c, n_c;
    logic [IW-1:0]     r_j, n_j;
    logic [POS_W-1:0]  r_pos_at, n_pos_at;
    logic              r_sat, n_sat;
    logic [CHAR_W-1:0] r_pat_q;
    logic [IW-1:0]     r_bor_q;

    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     bor_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [CHAR_W-1:0] wr_pat;
    logic [IW-1:0]     wr_bor;
    logic [IW-1:0]     start_j;
    logic              eq;
    logic [LW-1:0]     jn;

    assign bor_addr = rd_addr - IW'(1);
    assign start_j  = (LW'(r_cursor) >= r_len) ? '0 : r_cursor;
    assign eq       = (r_pat_q == r_c);
    assign jn       = LW'(r_j) + LW'(eq);

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_build    = r_build;
        n_cursor   = r_cursor;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_op       = r_op;
        n_c        = r_c;
        n_j        = r_j;
        n_pos_at   = r_pos_at;
        n_sat      = r_sat;
        rd_addr    = r_j;
        wr_en      = 1'b0;
        wr_addr    = r_len[IW-1:0];
        wr_pat     = r_c;
        wr_bor     = jn[IW-1:0];
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        o_res.found  = 1'b0;
        o_res.start  = '0;
        o_res.total  = r_cnt;
        o_res.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                // start only with room for the result word
                if (i_item_valid && !i_res_full) begin
                    o_item_pop = 1'b1;
                    n_op       = i_item.op;
                    n_c        = i_item.ch;
                    case (i_item.op)
                        OP_CLEAR: begin
                            n_len       = '0;
                            n_build     = '0;
                            n_cursor    = '0;
                            n_pos       = '0;
                            n_cnt       = '0;
                            o_res.total = '0;
                            o_res_push  = 1'b1;
                        end
                        OP_RESTART: begin
                            n_cursor    = '0;
                            n_pos       = '0;
                            n_cnt       = '0;
                            o_res.total = '0;
                            o_res_push  = 1'b1;
                        end
                        OP_APPEND: begin
                            if (r_len == LW'(MAX_PATTERN)) begin
                                o_res.status = ST_FULL;
                                o_res_push   = 1'b1;
                            end else if (r_len == '0) begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_pat     = i_item.ch;
                                wr_bor     = '0;
                                n_build    = '0;
                                n_len      = LW'(1);
                                o_res_push = 1'b1;
                            end else begin
                                n_j     = r_build;
                                rd_addr = r_build;
                                n_state = S_CMP;
                            end
                        end
                        OP_TEXT: begin
                            n_pos_at = r_pos;
                            n_sat    = &r_pos;
                            if (!(&r_pos)) begin
                                n_pos = r_pos + POS_W'(1);
                            end
                            if (r_len == '0) begin
                                o_res.status = ST_NOPAT;
                                o_res_push   = 1'b1;
                            end else begin
                                n_j     = start_j;
                                rd_addr = start_j;
                                n_state = S_CMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CMP: begin
                if (r_j != '0 && !eq) begin
                    // fall back along the border link, read the next pair at once
                    n_j     = r_bor_q;
                    rd_addr = r_bor_q;
                end else begin
                    n_state    = S_IDLE;
                    o_res_push = 1'b1;
                    if (r_op == OP_APPEND) begin
                        wr_en   = 1'b1;
                        n_build = jn[IW-1:0];
                        n_len   = r_len + LW'(1);
                    end else begin
                        o_res.status = r_sat ? ST_POSSAT : ST_OK;
                        if (jn == r_len) begin
                            if (r_cnt < r_max) begin
                                n_cnt       = r_cnt + CNT_W'(1);
                                o_res.found = 1'b1;
                                o_res.start = r_pos_at - (POS_W'(r_len) - POS_W'(1));
                                o_res.total = r_cnt + CNT_W'(1);
                            end else begin
                                o_res.status = ST_LIMIT;
                            end
                            n_cursor = r_build;
                        end else begin
                            n_cursor = jn[IW-1:0];
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_pat[wr_addr] <= wr_pat;
            mem_bor[wr_addr] <= wr_bor;
        end
        r_pat_q <= mem_pat[rd_addr];
        r_bor_q <= mem_bor[bor_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_build  <= '0;
            r_cursor <= '0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_max    <= '1;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_build  <= n_build;
            r_cursor <= n_cursor;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_c      <= n_c;
        r_j      <= n_j;
        r_pos_at <= n_pos_at;
        r_sat    <= n_sat;
    end

endmodule

`default_nettype wire

### sv/kmp_result_q.sv
// kmp_result_q: output queue of result words toward the consumer.
// Depends on kmp_pkg (t_result, Q_DEPTH).
`default_nettype none

module kmp_result_q (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire kmp_pkg::t_result i_res,
    output logic                  o_full,
    output logic                  o_empty,
    output kmp_pkg::t_result      o_res,
    input  wire logic             i_pop
);
    import kmp_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_result         r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            wr;
    logic            rd;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + CW'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### sv/kmp_checker.sv
// kmp_checker: port-level assertions for kmp_stream_matcher, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module kmp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        o_match_found,
    input wire logic [31:0] o_match_start,
    input wire logic [15:0] o_match_total,
    input wire logic [2:0]  o_status
);

    // words accepted but not yet delivered
    logic [3:0] r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'(push && !full) - 4'(pop && !empty);
        end
    end

    // reset leaves the result queue empty and the request queue not full
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_match_found) && $stable(o_match_start)
                              && $stable(o_match_total) && $stable(o_status)))
        else $error("result word changed while stalled");

    // no result without an accepted request
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == 4'd0) |-> empty)
        else $error("result shown with no outstanding request");

    // at most two queued requests, one in the engine sharing room with two results
    a_pending_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 4'd4)
        else $error("more words in flight than the queues hold");

endmodule

bind kmp_stream_matcher kmp_checker u_checker (.*);

`default_nettype wire

### tb/kmp_stream_matcher_tb.sv
// Self-checking testbench for kmp_stream_matcher: directed and random words on the
// request queue, each result checked against an in-bench KMP match tracker.
// Depends on kmp_pkg and the kmp_stream_matcher RTL only.
`timescale 1ns / 1ps

import kmp_pkg::*;

// Tracks pattern, border links and text state the way the matcher should, and
// holds the results still owed by the block, oldest first.
class kmp_match_tracker;
    localparam int PAT_MAX = DEF_MAX_PATTERN;

    logic [CHAR_W-1:0] pattern_bytes [PAT_MAX];
    logic [5:0]        border_links [PAT_MAX];
    logic [6:0]        pattern_len;
    logic [5:0]        running_border;
    logic [5:0]        cursor;
    logic [POS_W-1:0]  next_pos;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  hit_limit;
    t_result           owed_results[$];
    int                errors;

    function new();
        pattern_len    = '0;
        running_border = '0;
        cursor         = '0;
        next_pos       = '0;
        hits           = '0;
        hit_limit      = '1;
        errors         = 0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] value);
        hit_limit = value;
    endfunction

    // Work out the result of one accepted word and queue it.
    function void note_word(t_op op, logic [CHAR_W-1:0] ch);
        t_result          r;
        logic [POS_W-1:0] at;
        int               j;
        int               k;
        int               n;
        r = '0;
        case (op)
            OP_CLEAR: begin
                pattern_len    = '0;
                running_border = '0;
                cursor         = '0;
                next_pos       = '0;
                hits           = '0;
            end
            OP_RESTART: begin
                cursor   = '0;
                next_pos = '0;
                hits     = '0;
            end
            OP_APPEND: begin
                if (pattern_len >= PAT_MAX) begin
                    r.status = ST_FULL;
                end else begin
                    n = pattern_len;
                    pattern_bytes[n] = ch;
                    if (n == 0) begin
                        border_links[0] = '0;
                        running_border  = '0;
                    end else begin
                        k = running_border;
                        while (k > 0 && pattern_bytes[k] != ch)
                            k = border_links[k-1];
                        if (pattern_bytes[k] == ch)
                            k++;
                        border_links[n] = 6'(k);
                        running_border  = 6'(k);
                    end
                    pattern_len = 7'(n + 1);
                end
            end
            default: begin
                at = next_pos;
                r.status = (at == '1) ? ST_POSSAT : ST_OK;
                if (at != '1)
                    next_pos = at + POS_W'(1);
                if (pattern_len == 0) begin
                    r.status = ST_NOPAT;
                end else begin
                    j = cursor;
                    if (j >= pattern_len)
                        j = 0;
                    while (j > 0 && pattern_bytes[j] != ch)
                        j = border_links[j-1];
                    if (pattern_bytes[j] == ch)
                        j++;
                    if (j == pattern_len) begin
                        if (hits < hit_limit) begin
                            hits++;
                            r.found = 1'b1;
                            r.start = at - (POS_W'(pattern_len) - POS_W'(1));
                        end else begin
                            r.status = ST_LIMIT;
                        end
                        j = border_links[pattern_len-1];
                    end
                    cursor = 6'(j);
                end
            end
        endcase
        r.total = hits;
        owed_results.push_back(r);
    endfunction

    function void compare_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Check one popped word against the oldest owed result.
    function void check_word(logic found, logic [POS_W-1:0] start,
                             logic [CNT_W-1:0] total, logic [ST_W-1:0] status);
        t_result want;
        if (owed_results.size() == 0) begin
            $display("%0t: result with none owed, expected nothing, %s%0d %s%0d %s%0d %s%0d",
                     $time, "actual found=", found, "start=", start,
                     "total=", total, "status=", status);
            errors++;
            return;
        end
        want = owed_results.pop_front();
        compare_field("match_found", want.found, found);
        compare_field("match_start", want.start, start);
        compare_field("match_total", want.total, total);
        compare_field("status", want.status, status);
    endfunction
endclass

module kmp_stream_matcher_tb;

    localparam int LIMIT_CYCLES = 600000;
    localparam int WORD_GOAL    = 1500;
    localparam int PAT_MAX      = DEF_MAX_PATTERN;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [CNT_W-1:0]  cfg_wdata  = '0;
    logic              push       = 1'b0;
    logic [REQ_W-1:0]  req_type   = '0;
    logic [CHAR_W-1:0] char_value = '0;
    logic              pop        = 1'b0;
    logic              full;
    logic              empty;
    logic              o_match_found;
    logic [POS_W-1:0]  o_match_start;
    logic [CNT_W-1:0]  o_match_total;
    logic [ST_W-1:0]   o_status;

    kmp_match_tracker tracker = new();

    // Idling switches for each side, and a long receiver hold-off requested by the
    // main sequence and served by the receiver process.
    bit tx_gaps     = 1'b0;
    bit rx_gaps     = 1'b0;
    int rx_hold     = 0;
    int cycle_count = 0;
    int words_sent  = 0;
    int phase       = 0;

    kmp_stream_matcher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .push          (push),
        .full          (full),
        .i_req_type    (req_type),
        .i_char_value  (char_value),
        .empty         (empty),
        .pop           (pop),
        .o_match_found (o_match_found),
        .o_match_start (o_match_start),
        .o_match_total (o_match_total),
        .o_status      (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: pop a word per cycle unless stalled; stalls come as short random
    // bursts or as one long hold-off that fills the block up.
    initial begin : receiver
        int stall;
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 7);
            end else begin
                stall = 0;
            end
            repeat (stall) begin
                @(negedge i_clk);
                pop <= 1'b0;
                @(posedge i_clk);
            end
            @(negedge i_clk);
            pop <= 1'b1;
            @(posedge i_clk);
            if (i_rst_n && !empty)
                tracker.check_word(o_match_found, o_match_start, o_match_total, o_status);
        end
    end

    // Drop push and hold it low; n sets how long.
    task automatic pause_sender(int n);
        repeat (n) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
    endtask

    // Offer one word and hold it until the block takes it.
    task automatic send_word(t_op op, logic [CHAR_W-1:0] ch);
        if (tx_gaps && $urandom_range(0, 4) == 0)
            pause_sender($urandom_range(1, 7));
        @(negedge i_clk);
        push       <= 1'b1;
        req_type   <= op;
        char_value <= ch;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        tracker.note_word(op, ch);
        words_sent++;
    endtask

    // Hold the sender until every owed result has come back.
    task automatic drain();
        pause_sender(1);
        while (tracker.owed_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write max_matches with the block idle.
    task automatic write_limit(logic [CNT_W-1:0] value);
        drain();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        tracker.set_limit(value);
    endtask

    function automatic logic [CNT_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CNT_W'($urandom_range(1, 3));
            3:       return CNT_W'($urandom);
            default: return CNT_W'($urandom_range(2, 20));
        endcase
    endfunction

    // Clear, load a pattern over a tiny alphabet, then stream text mostly from the
    // same alphabet so matches, fallbacks and overlaps happen often. Sprinkle in
    // restarts, late appends and stray bytes.
    task automatic matching_phase(int plen);
        logic [CHAR_W-1:0] alpha [3];
        int                span;
        int                n_text;
        int                pick;
        span = $urandom_range(2, 3);
        foreach (alpha[i])
            alpha[i] = CHAR_W'($urandom);
        send_word(OP_CLEAR, CHAR_W'($urandom));
        repeat (plen)
            send_word(OP_APPEND, alpha[$urandom_range(0, span-1)]);
        n_text = $urandom_range(20, 60);
        repeat (n_text) begin
            pick = $urandom_range(0, 39);
            if (pick == 0)
                send_word(OP_RESTART, CHAR_W'($urandom));
            else if (pick == 1)
                send_word(OP_APPEND, alpha[$urandom_range(0, span-1)]);
            else if (pick == 2)
                send_word(OP_TEXT, CHAR_W'($urandom));
            else
                send_word(OP_TEXT, alpha[$urandom_range(0, span-1)]);
        end
    endtask

    // Any code, any byte.
    task automatic noise_phase();
        repeat (20)
            send_word(t_op'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
    endtask

    initial begin : main_sequence
        int plen;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: text without a pattern, overlapping matches, an append
        // during text, restart and clear, then the match limit at zero and one.
        write_limit('1);
        send_word(OP_TEXT, 8'h00);
        send_word(OP_TEXT, 8'hFF);
        repeat (3) send_word(OP_APPEND, 8'hAA);
        repeat (5) send_word(OP_TEXT, 8'hAA);
        send_word(OP_APPEND, 8'h55);
        send_word(OP_TEXT, 8'h55);
        send_word(OP_RESTART, 8'hFF);
        send_word(OP_CLEAR, 8'hFF);
        send_word(OP_APPEND, 8'hFF);
        send_word(OP_APPEND, 8'h00);
        send_word(OP_TEXT, 8'hFF);
        send_word(OP_TEXT, 8'h00);
        write_limit('0);
        send_word(OP_TEXT, 8'hFF);
        send_word(OP_TEXT, 8'h00);
        write_limit(16'd1);
        send_word(OP_RESTART, 8'h00);
        repeat (2) begin
            send_word(OP_TEXT, 8'hFF);
            send_word(OP_TEXT, 8'h00);
        end

        // Random part. The first phase overfills the pattern; the third one stalls
        // the receiver for a long stretch while the sender keeps pushing.
        while (words_sent < WORD_GOAL) begin
            phase++;
            if (phase % 4 == 0)
                write_limit(pick_limit());
            tx_gaps = (words_sent < WORD_GOAL * 85 / 100) && $urandom_range(0, 3) != 0;
            rx_gaps = (words_sent < WORD_GOAL * 85 / 100) && $urandom_range(0, 3) != 0;
            if (phase == 3) begin
                tx_gaps = 1'b0;
                rx_hold = 300;
                repeat (40)
                    send_word(OP_TEXT, CHAR_W'($urandom));
                drain();
            end
            if (phase == 1) begin
                matching_phase(PAT_MAX + 2);
            end else if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 19) == 0)
                    plen = $urandom_range(30, PAT_MAX + 3);
                else
                    plen = $urandom_range(1, 5);
                matching_phase(plen);
            end else begin
                noise_phase();
            end
        end

        // Let everything owed come back, then watch a little longer for strays.
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.owed_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
